FILE: rtl/core/sli_pkg.sv
// Shared types and constants of the sigmoid table interpolator.
`default_nettype none

package sli_pkg;

  // Command codes carried by an input transaction.
  typedef enum logic [1:0] {
    CMD_WRITE    = 2'd0,
    CMD_FORWARD  = 2'd1,
    CMD_BACKWARD = 2'd2
  } cmd_t;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_MIN_X        = 2'd0,
    REG_MAX_X        = 2'd1,
    REG_INDEX_SCALE  = 2'd2,
    REG_ENTRIES_USED = 2'd3
  } reg_index_t;

  localparam int CFG_DATA_W = 32;
  localparam int FRAC_BITS  = 27;
  localparam logic [27:0] FRAC_ONE = 28'h8000000;
  localparam logic [63:0] ROUND_HALF = 64'h4000000;

  localparam logic [15:0] MIN_X_RESET        = 16'hC000;
  localparam logic [15:0] MAX_X_RESET        = 16'h4000;
  localparam logic [31:0] INDEX_SCALE_RESET  = 32'd1044480;
  localparam logic [8:0]  ENTRIES_USED_RESET = 9'd256;

  typedef struct packed {
    logic [1:0]          cmd;
    logic signed [15:0]  x_value;
    logic signed [15:0]  grad_in;
    logic [7:0]          entry_index;
    logic [15:0]         entry_value;
  } in_t;

  typedef struct packed {
    logic signed [31:0]  result_value;
    logic                is_gradient;
  } out_t;

  typedef struct packed {
    logic signed [15:0]  min_x;
    logic signed [15:0]  max_x;
    logic [31:0]         index_scale;
    logic [8:0]          entries_used;
  } cfg_t;

  // Located item handed from the index stages to the interpolation stages.
  typedef struct packed {
    logic                has_result;
    logic                is_grad;
    logic                in_range;
    logic                wr_req;
    logic signed [15:0]  grad;
    logic [15:0]         entry_value;
    logic [27:0]         frac;
  } loc_t;

endpackage

`default_nettype wire

FILE: rtl/core/sli_ram.sv
// Generic RAM with one write port and two registered read ports.
`default_nettype none

module sli_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr_a,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr_b,
  output logic      [WIDTH-1:0]         rd_data_a,
  output logic      [WIDTH-1:0]         rd_data_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/sli_locate.sv
// Range check, index scaling and table address generation (three stages).
`default_nettype none

module sli_locate #(
  parameter int TABLE_DEPTH = 256
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire sli_pkg::cfg_t                  cfg,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire sli_pkg::in_t                   in_data,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output sli_pkg::loc_t                       out_data,
  output logic [$clog2(TABLE_DEPTH)-1:0]      rd_addr_a,
  output logic [$clog2(TABLE_DEPTH)-1:0]      rd_addr_b,
  output logic [$clog2(TABLE_DEPTH)-1:0]      wr_addr
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  logic r1, r2, r3;
  logic s1_valid, s2_valid, s3_valid;
  sli_pkg::in_t s1_item, s2_item, s3_item;

  logic signed [16:0] diff;
  logic below, above;
  logic s2_below, s2_inside, s3_below, s3_inside;
  logic [15:0] s2_diff;
  logic [47:0] prod;
  logic [47:0] s3_d;

  logic [CW-1:0] e;
  logic [CW-1:0] lim;
  logic [20:0] idx_raw;
  logic clamp;
  logic [AW-1:0] lower;
  logic wr_ok;

  assign r3 = !s3_valid || out_ready;
  assign r2 = !s2_valid || r3;
  assign r1 = !s1_valid || r2;
  assign in_ready = r1;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      if (r1) begin
        s1_valid <= in_valid;
      end
      if (r2) begin
        s2_valid <= s1_valid;
      end
      if (r3) begin
        s3_valid <= s2_valid;
      end
    end
  end

  // Stage 1 to 2: distance from the lower range end and the range test.
  assign diff  = 17'(s1_item.x_value) - 17'(cfg.min_x);
  assign below = s1_item.x_value <= cfg.min_x;
  assign above = s1_item.x_value >= cfg.max_x;

  // Stage 2 to 3: fractional index with 27 fraction bits.
  assign prod = s2_diff * cfg.index_scale;

  always_ff @(posedge clk) begin
    if (r1 && in_valid) begin
      s1_item <= in_data;
    end
    if (r2 && s1_valid) begin
      s2_item   <= s1_item;
      s2_below  <= below;
      s2_inside <= !below && !above;
      s2_diff   <= diff[15:0];
    end
    if (r3 && s2_valid) begin
      s3_item   <= s2_item;
      s3_below  <= s2_below;
      s3_inside <= s2_inside;
      s3_d      <= prod;
    end
  end

  // Stage 3: limit the lower index and form the read addresses.
  always_comb begin
    if (cfg.entries_used < 9'd2) begin
      e = CW'(2);
    end else if (32'(cfg.entries_used) > 32'(TABLE_DEPTH)) begin
      e = CW'(TABLE_DEPTH);
    end else begin
      e = CW'(cfg.entries_used);
    end
  end

  assign lim     = e - CW'(2);
  assign idx_raw = s3_d[47:sli_pkg::FRAC_BITS];
  assign clamp   = 32'(idx_raw) > 32'(lim);
  assign lower   = clamp ? AW'(lim) : AW'(idx_raw);
  assign wr_ok   = 32'(s3_item.entry_index) < 32'(TABLE_DEPTH);

  always_comb begin
    if (s3_below) begin
      rd_addr_a = '0;
    end else if (!s3_inside) begin
      rd_addr_a = AW'(e - CW'(1));
    end else begin
      rd_addr_a = lower;
    end
  end

  assign rd_addr_b = lower + AW'(1);
  assign wr_addr   = AW'(s3_item.entry_index);

  always_comb begin
    out_data = '0;
    out_data.has_result  = (s3_item.cmd == sli_pkg::CMD_FORWARD) ||
                           (s3_item.cmd == sli_pkg::CMD_BACKWARD);
    out_data.is_grad     = s3_item.cmd == sli_pkg::CMD_BACKWARD;
    out_data.in_range    = s3_inside;
    out_data.wr_req      = (s3_item.cmd == sli_pkg::CMD_WRITE) && wr_ok;
    out_data.grad        = s3_item.grad_in;
    out_data.entry_value = s3_item.entry_value;
    // Outside the range the fraction is zero, so a forward item returns the
    // boundary entry unchanged.
    if (!s3_inside) begin
      out_data.frac = '0;
    end else if (clamp) begin
      out_data.frac = sli_pkg::FRAC_ONE;
    end else begin
      out_data.frac = {1'b0, s3_d[sli_pkg::FRAC_BITS-1:0]};
    end
  end

  assign out_valid = s3_valid;

`ifndef SYNTHESIS
  a_addr_pair: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.in_range |->
      (32'(rd_addr_a) + 1 == 32'(rd_addr_b)) && (32'(rd_addr_a) + 2 <= 32'(e)))
    else $error("interpolation addresses out of the used table");
  a_frac_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.frac <= sli_pkg::FRAC_ONE) &&
                  (out_data.in_range || out_data.frac == '0))
    else $error("fraction out of range");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/sli_interp.sv
// Interpolation, gradient product, rounding and saturation (three stages).
`default_nettype none

module sli_interp (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic [31:0]   index_scale,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire sli_pkg::loc_t in_data,
  input  wire logic [15:0]   rd_data_a,
  input  wire logic [15:0]   rd_data_b,
  output logic               out_valid,
  input  wire logic          out_ready,
  output sli_pkg::out_t      out_data
);

  logic r4, r5, r6, r_out;
  logic s4_valid, s5_valid, s6_valid;

  logic s4_is_grad, s4_inside;
  logic signed [15:0] s4_grad;
  logic [27:0] s4_frac;

  logic signed [16:0] delta;
  logic signed [28:0] frac_s;
  logic signed [45:0] fprod;
  logic [15:0] ag, ad;
  logic [31:0] bprod;
  logic neg;

  logic s5_is_grad, s5_inside, s5_neg;
  logic signed [45:0] s5_fprod;
  logic [15:0] s5_y0;
  logic [31:0] s5_bprod;

  logic signed [46:0] ft;
  logic signed [19:0] fwd_sum;
  logic [63:0] bmag;

  logic s6_is_grad, s6_inside, s6_neg;
  logic [15:0] s6_fwd;
  logic [63:0] s6_bmag;

  logic [63:0] bsum;
  logic [36:0] rnd;
  sli_pkg::out_t res;

  assign r_out = !out_valid || out_ready;
  assign r6    = !s6_valid || r_out;
  assign r5    = !s5_valid || r6;
  assign r4    = !s4_valid || r5;
  assign in_ready = r4;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid  <= 1'b0;
      s5_valid  <= 1'b0;
      s6_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (r4) begin
        s4_valid <= in_valid && in_data.has_result;
      end
      if (r5) begin
        s5_valid <= s4_valid;
      end
      if (r6) begin
        s6_valid <= s5_valid;
      end
      if (r_out) begin
        out_valid <= s6_valid;
      end
    end
  end

  // Stage 4: sample difference, forward product and gradient magnitude product.
  assign delta  = $signed({1'b0, rd_data_b}) - $signed({1'b0, rd_data_a});
  assign frac_s = $signed({1'b0, s4_frac});
  assign fprod  = delta * frac_s;
  assign ag     = s4_grad[15] ? 16'(-s4_grad) : s4_grad;
  assign ad     = delta[16] ? 16'(-delta) : delta[15:0];
  assign bprod  = ag * ad;
  assign neg    = s4_grad[15] != delta[16];

  // Stage 5: forward rounding (halves upward) and the slope scaling product.
  assign ft      = 47'(s5_fprod) + 47'(sli_pkg::ROUND_HALF);
  assign fwd_sum = 20'(s5_y0) + ft[46:sli_pkg::FRAC_BITS];
  assign bmag    = 64'(s5_bprod) * 64'(index_scale);

  // Stage 6: gradient rounding to nearest and saturation.
  assign bsum = s6_bmag + sli_pkg::ROUND_HALF;
  assign rnd  = bsum[63:sli_pkg::FRAC_BITS];

  always_comb begin
    res = '0;
    res.is_gradient = s6_is_grad;
    if (!s6_is_grad) begin
      res.result_value = {16'b0, s6_fwd};
    end else if (!s6_inside) begin
      res.result_value = '0;
    end else if (s6_neg) begin
      if (rnd > 37'h080000000) begin
        res.result_value = 32'sh80000000;
      end else begin
        res.result_value = 32'(-rnd);
      end
    end else begin
      if (rnd > 37'h07FFFFFFF) begin
        res.result_value = 32'sh7FFFFFFF;
      end else begin
        res.result_value = rnd[31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (r4 && in_valid) begin
      s4_is_grad <= in_data.is_grad;
      s4_inside  <= in_data.in_range;
      s4_grad    <= in_data.grad;
      s4_frac    <= in_data.frac;
    end
    if (r5 && s4_valid) begin
      s5_is_grad <= s4_is_grad;
      s5_inside  <= s4_inside;
      s5_neg     <= neg;
      s5_fprod   <= fprod;
      s5_y0      <= rd_data_a;
      s5_bprod   <= bprod;
    end
    if (r6 && s5_valid) begin
      s6_is_grad <= s5_is_grad;
      s6_inside  <= s5_inside;
      s6_neg     <= s5_neg;
      s6_fwd     <= fwd_sum[15:0];
      s6_bmag    <= bmag;
    end
    if (r_out && s6_valid) begin
      out_data <= res;
    end
  end

`ifndef SYNTHESIS
  a_fwd_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.is_gradient |-> out_data.result_value[31:16] == '0)
    else $error("forward result outside the sample range");
  a_ram_hold: assert property (@(posedge clk) disable iff (rst)
    s4_valid && !r5 |=> $stable(rd_data_a) && $stable(rd_data_b))
    else $error("table read data changed under a stalled lookup stage");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/sigmoid_lut_interpolator.sv
// Top level of the piecewise linear sigmoid table interpolator.
//
// Usage: software first fills the sample table with write transactions
// (cmd write, entry_index, entry_value) and sets the range and scale
// registers through the configuration port (cfg_wr_en, cfg_index,
// cfg_wr_data), which must be written only while no transaction is in
// flight; the block itself does not enforce this. Forward transactions
// return the interpolated sigmoid in Q0.16; backward transactions return
// the saturated Q16.16 gradient with is_gradient set. Write transactions
// and unused command codes return nothing. Throughput: one transaction per
// clock on both channels while the receiver keeps out_ready high. A result
// passes through three index stages, the table read, and three arithmetic
// stages ending in the output register.
// Writes reach the table at the same stage where lookups read it, so every
// lookup sees exactly the writes that were accepted before it.
// Reset clears the pipeline and loads the register defaults; the table
// contents are undefined until written.
// When the receiver stalls, the result holds in the output register and the
// stages behind it keep filling; in_ready drops only when all are occupied.
`default_nettype none

module sigmoid_lut_interpolator #(
  parameter int TABLE_DEPTH = 256
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire sli_pkg::in_t                      in_data,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output sli_pkg::out_t                          out_data,
  input  wire logic                              cfg_wr_en,
  input  wire logic [1:0]                        cfg_index,
  input  wire logic [sli_pkg::CFG_DATA_W-1:0]    cfg_wr_data
);

  localparam int AW = $clog2(TABLE_DEPTH);

  sli_pkg::cfg_t cfg;
  logic loc_valid, int_ready;
  sli_pkg::loc_t loc_data;
  logic [AW-1:0] rd_addr_a, rd_addr_b, wr_addr;
  logic [15:0] rd_data_a, rd_data_b;
  logic ram_re, ram_we;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_x        <= sli_pkg::MIN_X_RESET;
      cfg.max_x        <= sli_pkg::MAX_X_RESET;
      cfg.index_scale  <= sli_pkg::INDEX_SCALE_RESET;
      cfg.entries_used <= sli_pkg::ENTRIES_USED_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        sli_pkg::REG_MIN_X:        cfg.min_x        <= cfg_wr_data[15:0];
        sli_pkg::REG_MAX_X:        cfg.max_x        <= cfg_wr_data[15:0];
        sli_pkg::REG_INDEX_SCALE:  cfg.index_scale  <= cfg_wr_data[31:0];
        sli_pkg::REG_ENTRIES_USED: cfg.entries_used <= cfg_wr_data[8:0];
        default: begin
        end
      endcase
    end
  end

  sli_locate #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_locate (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (loc_valid),
    .out_ready (int_ready),
    .out_data  (loc_data),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .wr_addr   (wr_addr)
  );

  // The table is read and written only when a transaction moves from the
  // index stages into the arithmetic stages, which keeps the read data
  // stable while the lookup stage is stalled.
  assign ram_re = loc_valid && int_ready;
  assign ram_we = ram_re && loc_data.wr_req;

  sli_ram #(
    .WIDTH (16),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk       (clk),
    .wr_en     (ram_we),
    .wr_addr   (wr_addr),
    .wr_data   (loc_data.entry_value),
    .rd_en     (ram_re),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_a (rd_data_a),
    .rd_data_b (rd_data_b)
  );

  sli_interp u_interp (
    .clk         (clk),
    .rst         (rst),
    .index_scale (cfg.index_scale),
    .in_valid    (loc_valid),
    .in_ready    (int_ready),
    .in_data     (loc_data),
    .rd_data_a   (rd_data_a),
    .rd_data_b   (rd_data_b),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data)
  );

endmodule

`default_nettype wire

FILE: dv/tb_sigmoid_lut_interpolator.sv
// Self-checking testbench for the sigmoid table interpolator, with its own prediction of every result.
`timescale 1ns / 100ps

module tb_sigmoid_lut_interpolator;

  localparam int LUT_DEPTH = 256;
  // Position arithmetic: (x - min_x) * index_scale carries 27 fraction bits.
  localparam int POS_FRAC = 27;
  localparam longint unsigned POS_ONE  = 64'd1 << POS_FRAC;
  localparam longint unsigned POS_HALF = POS_ONE >> 1;
  // The command field has one code that the package leaves unnamed.
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  localparam int HOLD_CYCLES   = 80;      // long receiver hold-off
  localparam int SETTLE_CYCLES = 12;      // pipeline depth plus margin before a register write
  localparam int END_CYCLES    = 20;      // quiet time after the last result
  localparam int RUN_LIMIT     = 400000;  // watchdog, in clock cycles

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  sli_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  sli_pkg::out_t out_data;
  logic cfg_wr_en = 1'b0;
  logic [1:0] cfg_index = sli_pkg::REG_MIN_X;
  logic [sli_pkg::CFG_DATA_W-1:0] cfg_wr_data = '0;

  // Mirror of the block's state: sample table and configuration registers.
  logic [15:0] sample_mirror [LUT_DEPTH];
  sli_pkg::cfg_t cfg_mirror = '{min_x: sli_pkg::MIN_X_RESET,
                                max_x: sli_pkg::MAX_X_RESET,
                                index_scale: sli_pkg::INDEX_SCALE_RESET,
                                entries_used: sli_pkg::ENTRIES_USED_RESET};

  // Results still owed by the block, oldest first.
  sli_pkg::out_t awaited_results[$];

  typedef struct {
    sli_pkg::in_t  item;
    bit            typed;
    sli_pkg::out_t want;
  } directed_row_t;
  directed_row_t directed_rows[$];

  int mismatch_count = 0;
  int cycle_count = 0;
  bit tx_steady = 1'b0;
  bit rx_steady = 1'b0;
  bit long_hold_req = 1'b0;

  sigmoid_lut_interpolator #(.TABLE_DEPTH(LUT_DEPTH)) uut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wr_data(cfg_wr_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Computes the result of a forward or backward transaction against the
  // mirrored table and registers. Returns 0 for commands that yield nothing.
  function automatic bit interp_expect(input sli_pkg::in_t item, output sli_pkg::out_t res);
    int xv, gv, lo, hi;
    int unsigned ent;
    longint unsigned pos, lower, frac, ag, ad, mag;
    longint y0, y1, delta, acc;
    bit neg;
    res = '0;
    if (item.cmd != sli_pkg::CMD_FORWARD && item.cmd != sli_pkg::CMD_BACKWARD) return 1'b0;
    xv = $signed(item.x_value);
    gv = $signed(item.grad_in);
    lo = $signed(cfg_mirror.min_x);
    hi = $signed(cfg_mirror.max_x);
    ent = cfg_mirror.entries_used;
    if (ent < 2) ent = 2;
    if (ent > LUT_DEPTH) ent = LUT_DEPTH;
    res.is_gradient = (item.cmd == sli_pkg::CMD_BACKWARD);
    // Outside the open range a forward item clamps to an end sample and a
    // backward item has zero slope. An empty range always lands here.
    if (xv <= lo || xv >= hi) begin
      if (item.cmd == sli_pkg::CMD_FORWARD)
        res.result_value = (xv <= lo) ? sample_mirror[0] : sample_mirror[ent - 1];
      return 1'b1;
    end
    pos = longint'(xv - lo) * longint'(cfg_mirror.index_scale);
    lower = pos >> POS_FRAC;
    if (lower > ent - 2) lower = ent - 2;
    frac = pos - (lower << POS_FRAC);
    if (frac > POS_ONE) frac = POS_ONE;
    y0 = sample_mirror[lower];
    y1 = sample_mirror[lower + 1];
    delta = y1 - y0;
    if (item.cmd == sli_pkg::CMD_FORWARD) begin
      // Round half up: add one half, then floor with an arithmetic shift.
      acc = delta * longint'(frac) + longint'(POS_HALF);
      res.result_value = 32'(y0 + (acc >>> POS_FRAC));
    end else begin
      // Sign and magnitude, so the rounding goes half away from zero.
      neg = (gv < 0) != (delta < 0);
      ag = (gv < 0) ? -gv : gv;
      ad = (delta < 0) ? -delta : delta;
      mag = ag * ad * longint'(cfg_mirror.index_scale);
      mag = (mag + POS_HALF) >> POS_FRAC;
      if (neg) begin
        if (mag > 64'h8000_0000) mag = 64'h8000_0000;
        res.result_value = 32'(-mag);
      end else begin
        if (mag > 64'h7FFF_FFFF) mag = 64'h7FFF_FFFF;
        res.result_value = 32'(mag);
      end
    end
    return 1'b1;
  endfunction

  function automatic sli_pkg::in_t make_item(input logic [1:0] op, input int x, input int g,
                                             input int slot, input int val);
    sli_pkg::in_t it;
    it.cmd = op;
    it.x_value = 16'(x);
    it.grad_in = 16'(g);
    it.entry_index = 8'(slot);
    it.entry_value = 16'(val);
    return it;
  endfunction

  // Random transaction shaped around the current range: most x values fall
  // strictly inside it, some sit on its ends, the rest span the whole field.
  function automatic sli_pkg::in_t random_item();
    sli_pkg::in_t it;
    int lo, hi, pick;
    it = make_item(sli_pkg::CMD_FORWARD, $urandom, $urandom, $urandom, $urandom);
    pick = $urandom_range(0, 99);
    if (pick < 55)      it.cmd = sli_pkg::CMD_FORWARD;
    else if (pick < 85) it.cmd = sli_pkg::CMD_BACKWARD;
    else if (pick < 97) it.cmd = sli_pkg::CMD_WRITE;
    else                it.cmd = CMD_UNUSED;
    lo = $signed(cfg_mirror.min_x);
    hi = $signed(cfg_mirror.max_x);
    pick = $urandom_range(0, 9);
    if (pick < 7 && hi - lo >= 2)
      it.x_value = 16'(lo + 1 + int'($urandom_range(0, hi - lo - 2)));
    else if (pick == 7)
      it.x_value = 16'(lo);
    else if (pick == 8)
      it.x_value = 16'(hi);
    if ($urandom_range(0, 7) == 0)
      it.grad_in = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
    return it;
  endfunction

  function automatic void add_row(input sli_pkg::in_t item, input bit typed, input int value,
                                  input bit grad);
    directed_row_t row;
    row.item = item;
    row.typed = typed;
    row.want.result_value = value;
    row.want.is_gradient = grad;
    directed_rows.push_back(row);
  endfunction

  // Offers one transaction and returns at the edge that accepts it. Valid is
  // lowered only when an idle gap follows, so back-to-back items keep it high.
  task automatic send_item(input sli_pkg::in_t item, input bit typed,
                           input sli_pkg::out_t typed_want, input bit eager);
    int unsigned gap;
    sli_pkg::out_t predicted;
    if ($urandom_range(0, 39) == 0) tx_steady = !tx_steady;
    gap = (eager || tx_steady) ? 0 : $urandom_range(0, 14);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (!in_ready);
    // Accepted: table writes take effect for every later lookup.
    if (item.cmd == sli_pkg::CMD_WRITE) sample_mirror[item.entry_index] = item.entry_value;
    if (typed)
      awaited_results.push_back(typed_want);
    else if (interp_expect(item, predicted))
      awaited_results.push_back(predicted);
  endtask

  // Stops offering, waits for every owed result, then lets the write and
  // unused transactions that yield nothing flush out of the pipeline.
  task automatic drain_pipeline();
    in_valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic put_reg(input sli_pkg::reg_index_t idx, input logic [31:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wr_data <= val;
    @(posedge clk);
  endtask

  task automatic load_config(input int lo, input int hi, input logic [31:0] scale,
                             input int ent);
    put_reg(sli_pkg::REG_MIN_X, 32'(lo));
    put_reg(sli_pkg::REG_MAX_X, 32'(hi));
    put_reg(sli_pkg::REG_INDEX_SCALE, scale);
    put_reg(sli_pkg::REG_ENTRIES_USED, 32'(ent));
    cfg_wr_en <= 1'b0;
    cfg_mirror.min_x = 16'(lo);
    cfg_mirror.max_x = 16'(hi);
    cfg_mirror.index_scale = scale;
    cfg_mirror.entries_used = 9'(ent);
  endtask

  task automatic run_phase(input int lo, input int hi, input logic [31:0] scale,
                           input int ent, input int count);
    drain_pipeline();
    load_config(lo, hi, scale, ent);
    repeat (count) send_item(random_item(), 1'b0, '0, 1'b0);
  endtask

  // Receiver: random back-pressure per transaction, steady stretches, and one
  // long hold-off on request that it times itself.
  initial begin : result_sink
    int unsigned stall;
    @(negedge rst);
    forever begin
      if (long_hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        long_hold_req = 1'b0;
      end
      if ($urandom_range(0, 39) == 0) rx_steady = !rx_steady;
      stall = rx_steady ? 0 : $urandom_range(0, 14);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Every accepted result is matched against the oldest owed one.
  always @(posedge clk) begin : result_check
    sli_pkg::out_t want;
    if (!rst && out_valid && out_ready) begin
      if (awaited_results.size() == 0) begin
        $error("unexpected result transaction: result_value %0d is_gradient %0b",
               out_data.result_value, out_data.is_gradient);
        mismatch_count++;
      end else begin
        want = awaited_results.pop_front();
        if (out_data.result_value !== want.result_value) begin
          $error("result_value: expected %0d, actual %0d",
                 want.result_value, out_data.result_value);
          mismatch_count++;
        end
        if (out_data.is_gradient !== want.is_gradient) begin
          $error("is_gradient: expected %0b, actual %0b",
                 want.is_gradient, out_data.is_gradient);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == RUN_LIMIT) begin
      $display("FAIL sigmoid_lut_interpolator");
      $finish;
    end
  end

  initial begin : stimulus
    int lo, hi, ent, eff;
    logic [31:0] scale;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Fill the whole table first, so that no lookup ever reads an unwritten
    // slot. Random content gives rising and falling neighbors alike.
    for (int slot = 0; slot < LUT_DEPTH; slot++)
      send_item(make_item(sli_pkg::CMD_WRITE, $urandom, $urandom, slot, $urandom),
                1'b0, '0, 1'b0);

    // Directed rows under the reset range [-16384, 16384], 256 entries.
    // End samples are set here so the clamped results can be typed in.
    add_row(make_item(sli_pkg::CMD_WRITE, 0, 0, 0, 16'h0000), 1'b0, 0, 1'b0);
    add_row(make_item(sli_pkg::CMD_WRITE, -1, -1, 1, 16'hFFFF), 1'b0, 0, 1'b0);
    add_row(make_item(sli_pkg::CMD_WRITE, 0, 0, 254, 16'h0000), 1'b0, 0, 1'b0);
    add_row(make_item(sli_pkg::CMD_WRITE, 0, 0, 255, 16'hFFFF), 1'b0, 0, 1'b0);
    // Below and at the lower end: first sample.
    add_row(make_item(sli_pkg::CMD_FORWARD, -32768, 0, 0, 0), 1'b1, 0, 1'b0);
    add_row(make_item(sli_pkg::CMD_FORWARD, -16384, 0, 0, 0), 1'b1, 0, 1'b0);
    // Above and at the upper end: last sample in use.
    add_row(make_item(sli_pkg::CMD_FORWARD, 32767, 0, 0, 0), 1'b1, 65535, 1'b0);
    add_row(make_item(sli_pkg::CMD_FORWARD, 16384, 0, 0, 0), 1'b1, 65535, 1'b0);
    // Backward outside the range has zero slope, whatever the gradient.
    add_row(make_item(sli_pkg::CMD_BACKWARD, -32768, 32767, 0, 0), 1'b1, 0, 1'b1);
    add_row(make_item(sli_pkg::CMD_BACKWARD, -16384, -32768, 0, 0), 1'b1, 0, 1'b1);
    add_row(make_item(sli_pkg::CMD_BACKWARD, 16384, 32767, 0, 0), 1'b1, 0, 1'b1);
    add_row(make_item(sli_pkg::CMD_BACKWARD, 32767, -32768, 0, 0), 1'b1, 0, 1'b1);
    // The unused command must not produce anything.
    add_row(make_item(CMD_UNUSED, -1, -1, 255, 16'hFFFF), 1'b0, 0, 1'b0);
    // Just inside either end, with full-scale rising slopes and gradients of both signs.
    add_row(make_item(sli_pkg::CMD_FORWARD, -16383, 0, 0, 0), 1'b0, 0, 1'b0);
    add_row(make_item(sli_pkg::CMD_BACKWARD, -16383, 32767, 0, 0), 1'b0, 0, 1'b0);
    add_row(make_item(sli_pkg::CMD_BACKWARD, -16383, -32768, 0, 0), 1'b0, 0, 1'b0);
    add_row(make_item(sli_pkg::CMD_FORWARD, 16383, 0, 0, 0), 1'b0, 0, 1'b0);
    add_row(make_item(sli_pkg::CMD_BACKWARD, 16383, -32768, 0, 0), 1'b0, 0, 1'b0);
    add_row(make_item(sli_pkg::CMD_BACKWARD, 16383, 32767, 0, 0), 1'b0, 0, 1'b0);
    // A write followed at once by a lookup of the same slot.
    add_row(make_item(sli_pkg::CMD_WRITE, 0, 0, 128, 16'h8000), 1'b0, 0, 1'b0);
    add_row(make_item(sli_pkg::CMD_FORWARD, 0, 0, 0, 0), 1'b0, 0, 1'b0);
    add_row(make_item(sli_pkg::CMD_BACKWARD, 0, 0, 0, 0), 1'b1, 0, 1'b1);
    add_row(make_item(sli_pkg::CMD_FORWARD, -1, 0, 0, 0), 1'b0, 0, 1'b0);
    add_row(make_item(sli_pkg::CMD_BACKWARD, 1, 1, 0, 0), 1'b0, 0, 1'b0);
    foreach (directed_rows[i])
      send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want, 1'b0);

    // Back-to-back traffic against a long receiver hold-off: the pipeline
    // fills and in_ready has to drop until the receiver resumes.
    long_hold_req = 1'b1;
    repeat (40)
      send_item(make_item(sli_pkg::CMD_FORWARD, int'($urandom_range(0, 32766)) - 16383,
                          $urandom, $urandom, $urandom), 1'b0, '0, 1'b1);

    // Register settings, each run after the pipeline has drained.
    run_phase(-16384, 16384, 32'd1044480, 256, 75);     // reset values again
    run_phase(-32768, 32767, 32'd255, 256, 75);         // widest range
    run_phase(-2048, 2048, 32'd16, 2, 75);              // fewest entries
    run_phase(-100, 100, 32'hFFFF_FFFF, 0, 75);         // count below 2, fraction clamps
    run_phase(-32768, 32767, 32'd0, 511, 75);           // zero scale, count above depth
    run_phase(1000, 1000, 32'd65536, 128, 75);          // empty range
    run_phase(32767, -32768, 32'd65536, 1, 75);         // inverted range
    run_phase(-4096, 4096, 32'hFFFF_FFFF, 256, 75);     // gradients saturate both ways
    run_phase(-8192, 8192, 32'd100000, 300, 75);
    repeat (3) begin
      lo = int'($urandom_range(0, 65535)) - 32768;
      hi = int'($urandom_range(0, 65535)) - 32768;
      if (lo > hi) begin
        ent = lo;
        lo = hi;
        hi = ent;
      end
      ent = $urandom_range(0, 511);
      eff = (ent < 2) ? 2 : (ent > LUT_DEPTH) ? LUT_DEPTH : ent;
      scale = (hi > lo) ? 32'(((longint'(eff) - 1) << 16) / (hi - lo)) : $urandom;
      run_phase(lo, hi, scale, ent, 75);
    end

    in_valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (END_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("PASS sigmoid_lut_interpolator");
    else
      $display("FAIL sigmoid_lut_interpolator");
    $finish;
  end

endmodule
